// File: hdl/satellite_geometric_range_assert.svh
// Assertion macros for the geometric range block.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef SATELLITE_GEOMETRIC_RANGE_ASSERT_SVH
`define SATELLITE_GEOMETRIC_RANGE_ASSERT_SVH
`ifndef SYNTHESIS
`define SGR_ASSERT_HOLDS(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgr: same-cycle check failed");
`define SGR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgr: next-cycle check failed");
`else
`define SGR_ASSERT_HOLDS(lbl, clk, rst, ante, cons)
`define SGR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hdl/sgr_pkg.sv
`timescale 1ns / 1ps
package sgr_pkg;

   // Fixed point and field widths
   localparam int POS_FRAC_BITS = 16;
   localparam int AXES          = 3;
   localparam int IN_W          = 48;
   localparam int REQ_DATA_W    = 2 * AXES * IN_W;
   localparam int RANGE_W       = 47;
   localparam int UNIT_W        = 32;
   localparam int RSP_DATA_W    = 144;

   // Datapath widths
   localparam int MAG_W  = 48;
   localparam int HALF_W = 24;
   localparam int PP_W   = 48;
   localparam int SQ_W   = 96;
   localparam int SUM_W  = 98;
   localparam int ROOT_W = 50;
   localparam int REM_W  = 100;
   localparam int K_W    = 31;
   localparam int CHUNK_W = 32;
   localparam int KPP_W  = CHUNK_W + K_W;
   localparam int PROD_W = SQ_W + K_W;
   localparam int TM_W   = 47;
   localparam int QUO_W  = 31;
   localparam int DREM_W = 52;
   localparam int TOT_W  = 52;
   localparam int PRE_N  = 8;

   // Earth rotation rate over light speed, scaled by 2^72
   localparam logic [K_W-1:0]    SAGNAC_K = 31'd1148662658;
   localparam int                SAG_SH   = 72 + POS_FRAC_BITS;
   localparam logic [PROD_W-1:0] SAG_RND  = PROD_W'(1) << (SAG_SH - 1);

   // Squared WGS84 equatorial radius in position units
   localparam logic [SUM_W-1:0] RE_FIX = SUM_W'(6378137) << POS_FRAC_BITS;
   localparam logic [SUM_W-1:0] RE_SQ  = RE_FIX * RE_FIX;

   typedef struct packed {
      logic [AXES-1:0][MAG_W-1:0] dmag;
      logic [AXES-1:0]            dsgn;
   } diff_type;

   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [TM_W-1:0]   tm;
      diff_type          diff;
   } root_side_type;

   typedef struct packed {
      logic               valid;
      logic               rzero;
      logic [RANGE_W-1:0] range;
      logic [ROOT_W-1:0]  root;
      logic [AXES-1:0]    dsgn;
   } div_side_type;

   typedef struct packed {
      logic                     valid_res;
      logic [RANGE_W-1:0]       range;
      logic signed [UNIT_W-1:0] unit_x;
      logic signed [UNIT_W-1:0] unit_y;
      logic signed [UNIT_W-1:0] unit_z;
   } rsp_type;

   function automatic logic [MAG_W-1:0] mag_in(input logic signed [IN_W-1:0] v);
      logic signed [IN_W-1:0] n;
      n = -v;
      return v[IN_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   function automatic logic [MAG_W-1:0] mag_diff(input logic signed [IN_W:0] v);
      logic signed [IN_W:0] n;
      n = -v;
      return v[IN_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   function automatic logic [PP_W-1:0] mul_half(input logic [HALF_W-1:0] a,
                                                input logic [HALF_W-1:0] b);
      logic [PP_W-1:0] r;
      r = a * b;
      return r;
   endfunction

   function automatic logic [KPP_W-1:0] mul_k(input logic [CHUNK_W-1:0] a);
      logic [KPP_W-1:0] r;
      r = a * SAGNAC_K;
      return r;
   endfunction

   function automatic logic [SQ_W-1:0] sq_join(input logic [PP_W-1:0] hh,
                                               input logic [PP_W-1:0] hl,
                                               input logic [PP_W-1:0] ll);
      return (SQ_W'(hh) << (2 * HALF_W)) + (SQ_W'(hl) << (HALF_W + 1)) + SQ_W'(ll);
   endfunction

   function automatic logic [SQ_W-1:0] prod_join(input logic [PP_W-1:0] hh,
                                                 input logic [PP_W-1:0] hl,
                                                 input logic [PP_W-1:0] lh,
                                                 input logic [PP_W-1:0] ll);
      return (SQ_W'(hh) << (2 * HALF_W)) + (SQ_W'(hl) << HALF_W)
           + (SQ_W'(lh) << HALF_W) + SQ_W'(ll);
   endfunction

endpackage

// File: hdl/satellite_geometric_range.sv
`timescale 1ns / 1ps
`include "satellite_geometric_range_assert.svh"
// Geometric range with Sagnac correction and line-of-sight unit vector for one
// satellite/receiver pair in ECEF, positions signed with 16 fractional bits.
// The block takes one item per clock while req_tready is high and returns one
// result per item, in order. The pipeline is an 8-stage front end (squares,
// cross product, Sagnac multiply), a 50-stage digit-by-digit square root, one
// rounding stage, one range/saturation stage and a 31-stage restoring divider
// shared in lanes by the three vector components. The output register plus a
// skid stage keep the pipeline moving while one result waits; req_tready drops
// only once the skid stage holds an item. A satellite inside the equatorial
// radius returns valid_res low with range and vector zero.
module satellite_geometric_range (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sat_x, sat_y, sat_z, rcv_x, rcv_y, rcv_z (48 bits each, from bit 0 up)
   input  logic [sgr_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // range (47), unit_x (32), unit_y (32), unit_z (32), one zero pad bit
   output logic [sgr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // valid_res
   output logic [0:0]                      rsp_tuser
);
   import sgr_pkg::*;

   logic en;
   logic out_v_ff, skid_v_ff;
   rsp_type out_ff, skid_ff, res_in;

   // Advance the whole pipeline while the skid stage is free
   assign en         = !skid_v_ff;
   assign req_tready = en;

   // Front end valid bits
   logic [PRE_N-1:0] pv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (en) begin
         pv_ff <= {pv_ff[PRE_N-2:0], req_tvalid};
      end
   end

   // Stage 0: capture positions
   logic signed [IN_W-1:0] sat0_ff [AXES];
   logic signed [IN_W-1:0] rcv0_ff [AXES];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < AXES; a++) begin
            sat0_ff[a] <= req_tdata[a*IN_W +: IN_W];
            rcv0_ff[a] <= req_tdata[(AXES+a)*IN_W +: IN_W];
         end
      end
   end

   // Stage 1: differences and magnitudes; carry the differences down the front end
   logic signed [IN_W:0] d1 [AXES];
   diff_type         diff_ff [1:PRE_N-2];
   logic [MAG_W-1:0] smag1_ff [AXES];
   logic [MAG_W-1:0] rmx1_ff, rmy1_ff;
   logic [1:0]       psg1_ff;
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         d1[a] = {sat0_ff[a][IN_W-1], sat0_ff[a]} - {rcv0_ff[a][IN_W-1], rcv0_ff[a]};
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < AXES; a++) begin
            diff_ff[1].dmag[a] <= mag_diff(d1[a]);
            diff_ff[1].dsgn[a] <= d1[a][IN_W];
            smag1_ff[a]        <= mag_in(sat0_ff[a]);
         end
         for (int k = 2; k <= PRE_N - 2; k++) begin
            diff_ff[k] <= diff_ff[k-1];
         end
         rmx1_ff    <= mag_in(rcv0_ff[0]);
         rmy1_ff    <= mag_in(rcv0_ff[1]);
         psg1_ff[0] <= sat0_ff[0][IN_W-1] ^ rcv0_ff[1][IN_W-1];
         psg1_ff[1] <= sat0_ff[1][IN_W-1] ^ rcv0_ff[0][IN_W-1];
      end
   end

   // Stage 2: 24 x 24 partial products
   logic [PP_W-1:0] dpp2_ff [AXES][3];
   logic [PP_W-1:0] spp2_ff [AXES][3];
   logic [PP_W-1:0] cpp2_ff [2][4];
   logic [1:0]      psg2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < AXES; a++) begin
            dpp2_ff[a][0] <= mul_half(diff_ff[1].dmag[a][MAG_W-1:HALF_W],
                                      diff_ff[1].dmag[a][MAG_W-1:HALF_W]);
            dpp2_ff[a][1] <= mul_half(diff_ff[1].dmag[a][MAG_W-1:HALF_W],
                                      diff_ff[1].dmag[a][HALF_W-1:0]);
            dpp2_ff[a][2] <= mul_half(diff_ff[1].dmag[a][HALF_W-1:0],
                                      diff_ff[1].dmag[a][HALF_W-1:0]);
            spp2_ff[a][0] <= mul_half(smag1_ff[a][MAG_W-1:HALF_W],
                                      smag1_ff[a][MAG_W-1:HALF_W]);
            spp2_ff[a][1] <= mul_half(smag1_ff[a][MAG_W-1:HALF_W],
                                      smag1_ff[a][HALF_W-1:0]);
            spp2_ff[a][2] <= mul_half(smag1_ff[a][HALF_W-1:0], smag1_ff[a][HALF_W-1:0]);
         end
         // sat_x * rcv_y
         cpp2_ff[0][0] <= mul_half(smag1_ff[0][MAG_W-1:HALF_W], rmy1_ff[MAG_W-1:HALF_W]);
         cpp2_ff[0][1] <= mul_half(smag1_ff[0][MAG_W-1:HALF_W], rmy1_ff[HALF_W-1:0]);
         cpp2_ff[0][2] <= mul_half(smag1_ff[0][HALF_W-1:0], rmy1_ff[MAG_W-1:HALF_W]);
         cpp2_ff[0][3] <= mul_half(smag1_ff[0][HALF_W-1:0], rmy1_ff[HALF_W-1:0]);
         // sat_y * rcv_x
         cpp2_ff[1][0] <= mul_half(smag1_ff[1][MAG_W-1:HALF_W], rmx1_ff[MAG_W-1:HALF_W]);
         cpp2_ff[1][1] <= mul_half(smag1_ff[1][MAG_W-1:HALF_W], rmx1_ff[HALF_W-1:0]);
         cpp2_ff[1][2] <= mul_half(smag1_ff[1][HALF_W-1:0], rmx1_ff[MAG_W-1:HALF_W]);
         cpp2_ff[1][3] <= mul_half(smag1_ff[1][HALF_W-1:0], rmx1_ff[HALF_W-1:0]);
         psg2_ff <= psg1_ff;
      end
   end

   // Stage 3: join partial products
   logic [SQ_W-1:0] dsq3_ff [AXES];
   logic [SQ_W-1:0] ssq3_ff [AXES];
   logic [SQ_W-1:0] cp3_ff [2];
   logic [1:0]      psg3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < AXES; a++) begin
            dsq3_ff[a] <= sq_join(dpp2_ff[a][0], dpp2_ff[a][1], dpp2_ff[a][2]);
            ssq3_ff[a] <= sq_join(spp2_ff[a][0], spp2_ff[a][1], spp2_ff[a][2]);
         end
         for (int p = 0; p < 2; p++) begin
            cp3_ff[p] <= prod_join(cpp2_ff[p][0], cpp2_ff[p][1], cpp2_ff[p][2],
                                   cpp2_ff[p][3]);
         end
         psg3_ff <= psg2_ff;
      end
   end

   // Stage 4: sums of squares and the signed cross product
   logic [SUM_W-1:0]        s4_ff, ssat4_ff;
   logic signed [SUM_W-1:0] c4_ff, c4_in, t1, t2;
   always_comb begin
      t1 = {2'b00, cp3_ff[0]};
      t2 = {2'b00, cp3_ff[1]};
      if (psg3_ff[0]) begin
         t1 = -t1;
      end
      if (psg3_ff[1]) begin
         t2 = -t2;
      end
      c4_in = t1 - t2;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff    <= SUM_W'(dsq3_ff[0]) + SUM_W'(dsq3_ff[1]) + SUM_W'(dsq3_ff[2]);
         ssat4_ff <= SUM_W'(ssq3_ff[0]) + SUM_W'(ssq3_ff[1]) + SUM_W'(ssq3_ff[2]);
         c4_ff    <= c4_in;
      end
   end

   // Stage 5: radius test and cross product magnitude
   logic [SUM_W-1:0]        s5_ff;
   logic                    valid5_ff, neg5_ff;
   logic [SQ_W-1:0]         cm5_ff;
   logic signed [SUM_W-1:0] cneg;
   assign cneg = -c4_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s5_ff     <= s4_ff;
         valid5_ff <= !(ssat4_ff < RE_SQ);
         neg5_ff   <= c4_ff[SUM_W-1];
         cm5_ff    <= c4_ff[SUM_W-1] ? cneg[SQ_W-1:0] : c4_ff[SQ_W-1:0];
      end
   end

   // Stage 6: Sagnac partial products
   logic [SUM_W-1:0]  s6_ff;
   logic              valid6_ff, neg6_ff;
   logic [KPP_W-1:0]  kpp6_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         s6_ff     <= s5_ff;
         valid6_ff <= valid5_ff;
         neg6_ff   <= neg5_ff;
         for (int j = 0; j < 3; j++) begin
            kpp6_ff[j] <= mul_k(cm5_ff[j*CHUNK_W +: CHUNK_W]);
         end
      end
   end

   // Stage 7: round the Sagnac term
   logic [SUM_W-1:0]  s7_ff;
   root_side_type     side7_ff;
   logic [PROD_W-1:0] prod7, tm_full;
   assign prod7   = PROD_W'(kpp6_ff[0]) + (PROD_W'(kpp6_ff[1]) << CHUNK_W)
                  + (PROD_W'(kpp6_ff[2]) << (2 * CHUNK_W)) + SAG_RND;
   assign tm_full = prod7 >> SAG_SH;
   always_ff @(posedge clock) begin
      if (en) begin
         s7_ff          <= s6_ff;
         side7_ff.valid <= valid6_ff;
         side7_ff.neg   <= neg6_ff;
         side7_ff.tm    <= tm_full[TM_W-1:0];
         side7_ff.diff  <= diff_ff[PRE_N-2];
      end
   end

   // Square root, one result bit per stage
   logic              sq_v_ff    [ROOT_W];
   logic [REM_W-1:0]  sq_rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [ROOT_W];
   root_side_type     sq_side_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      localparam int B = ROOT_W - 1 - k;
      logic              v_i;
      logic [REM_W-1:0]  rem_i, trial;
      logic [ROOT_W-1:0] root_i;
      root_side_type     side_i;
      if (k == 0) begin : g_first
         assign v_i    = pv_ff[PRE_N-1];
         assign rem_i  = REM_W'(s7_ff);
         assign root_i = '0;
         assign side_i = side7_ff;
      end else begin : g_next
         assign v_i    = sq_v_ff[k-1];
         assign rem_i  = sq_rem_ff[k-1];
         assign root_i = sq_root_ff[k-1];
         assign side_i = sq_side_ff[k-1];
      end
      assign trial = (REM_W'(root_i) << (B + 1)) | (REM_W'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k] <= v_i;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_i >= trial) begin
               sq_rem_ff[k]  <= rem_i - trial;
               sq_root_ff[k] <= root_i | (ROOT_W'(1) << B);
            end else begin
               sq_rem_ff[k]  <= rem_i;
               sq_root_ff[k] <= root_i;
            end
            sq_side_ff[k] <= side_i;
         end
      end
   end

   // Round the root to nearest
   logic              rd_v_ff;
   logic [ROOT_W-1:0] rd_root_ff, rd_root_in;
   root_side_type     rd_side_ff;
   assign rd_root_in = sq_root_ff[ROOT_W-1]
                     + ROOT_W'(sq_rem_ff[ROOT_W-1] > REM_W'(sq_root_ff[ROOT_W-1]));
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else if (en) begin
         rd_v_ff <= sq_v_ff[ROOT_W-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rd_root_ff <= rd_root_in;
         rd_side_ff <= sq_side_ff[ROOT_W-1];
      end
   end

   // Add the Sagnac term, saturate, and seed the dividers
   logic                     pp_v_ff;
   div_side_type             pp_side_ff;
   logic [DREM_W-1:0]        pp_rem_ff [AXES];
   logic signed [TOT_W-1:0]  root_s, tm_s, tot;
   logic [RANGE_W-1:0]       range_in;
   assign root_s = TOT_W'(rd_root_ff);
   assign tm_s   = TOT_W'(rd_side_ff.tm);
   always_comb begin
      tot = rd_side_ff.neg ? root_s - tm_s : root_s + tm_s;
      if (tot[TOT_W-1]) begin
         range_in = '0;
      end else if (|tot[TOT_W-2:RANGE_W]) begin
         range_in = '1;
      end else begin
         range_in = tot[RANGE_W-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         pp_v_ff <= 1'b0;
      end else if (en) begin
         pp_v_ff <= rd_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pp_side_ff.valid <= rd_side_ff.valid;
         pp_side_ff.rzero <= (rd_root_ff == '0);
         pp_side_ff.range <= range_in;
         pp_side_ff.root  <= rd_root_ff;
         pp_side_ff.dsgn  <= rd_side_ff.diff.dsgn;
         for (int a = 0; a < AXES; a++) begin
            pp_rem_ff[a] <= DREM_W'(rd_side_ff.diff.dmag[a])
                          + DREM_W'(rd_root_ff >> QUO_W);
         end
      end
   end

   // Restoring divide of (|d| * 2^31 + R) by 2R, one quotient bit per stage
   logic              dv_v_ff    [QUO_W];
   logic [DREM_W-1:0] dv_rem_ff  [QUO_W][AXES];
   logic [QUO_W-1:0]  dv_q_ff    [QUO_W][AXES];
   div_side_type      dv_side_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int I = QUO_W - 1 - j;
      logic              v_i;
      logic [DREM_W-1:0] rem_i [AXES];
      logic [DREM_W-1:0] shl   [AXES];
      logic [QUO_W-1:0]  q_i   [AXES];
      logic [DREM_W-1:0] dvsr;
      div_side_type      side_i;
      if (j == 0) begin : g_first
         assign v_i    = pp_v_ff;
         assign side_i = pp_side_ff;
         always_comb begin
            for (int a = 0; a < AXES; a++) begin
               rem_i[a] = pp_rem_ff[a];
               q_i[a]   = '0;
            end
         end
      end else begin : g_next
         assign v_i    = dv_v_ff[j-1];
         assign side_i = dv_side_ff[j-1];
         always_comb begin
            for (int a = 0; a < AXES; a++) begin
               rem_i[a] = dv_rem_ff[j-1][a];
               q_i[a]   = dv_q_ff[j-1][a];
            end
         end
      end
      assign dvsr = DREM_W'({side_i.root, 1'b0});
      always_comb begin
         for (int a = 0; a < AXES; a++) begin
            shl[a] = {rem_i[a][DREM_W-2:0], side_i.root[I]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (en) begin
            dv_v_ff[j] <= v_i;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            for (int a = 0; a < AXES; a++) begin
               if (shl[a] >= dvsr) begin
                  dv_rem_ff[j][a] <= shl[a] - dvsr;
                  dv_q_ff[j][a]   <= {q_i[a][QUO_W-2:0], 1'b1};
               end else begin
                  dv_rem_ff[j][a] <= shl[a];
                  dv_q_ff[j][a]   <= {q_i[a][QUO_W-2:0], 1'b0};
               end
            end
            dv_side_ff[j] <= side_i;
         end
      end
   end

   // Format the result: sign the vector, zero everything for a rejected item
   logic signed [UNIT_W-1:0] umag [AXES];
   logic signed [UNIT_W-1:0] unit [AXES];
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         umag[a] = {1'b0, dv_q_ff[QUO_W-1][a]};
         if (!dv_side_ff[QUO_W-1].valid || dv_side_ff[QUO_W-1].rzero) begin
            unit[a] = '0;
         end else if (dv_side_ff[QUO_W-1].dsgn[a]) begin
            unit[a] = -umag[a];
         end else begin
            unit[a] = umag[a];
         end
      end
      res_in.valid_res = dv_side_ff[QUO_W-1].valid;
      res_in.range     = dv_side_ff[QUO_W-1].valid ? dv_side_ff[QUO_W-1].range : '0;
      res_in.unit_x    = unit[0];
      res_in.unit_y    = unit[1];
      res_in.unit_z    = unit[2];
   end

   // Output register with skid stage
   logic push, pop;
   assign push = en && dv_v_ff[QUO_W-1];
   assign pop  = out_v_ff && rsp_tready;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         out_v_ff <= 1'b1;
         if (out_v_ff && !pop) begin
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_v_ff && !pop) begin
            skid_ff <= res_in;
         end else begin
            out_ff <= res_in;
         end
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = {1'b0, out_ff.unit_z, out_ff.unit_y, out_ff.unit_x, out_ff.range};
   assign rsp_tuser[0] = out_ff.valid_res;

   // Checks
   `SGR_ASSERT_HOLDS(a_skid_needs_out, clock, reset, skid_v_ff, out_v_ff)
   `SGR_ASSERT_HOLDS(a_reject_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)
   `SGR_ASSERT_HOLDS(a_unit_bound, clock, reset, rsp_tvalid, (out_ff.unit_x <= 32'sd1073741824) && (out_ff.unit_x >= -32'sd1073741824) && (out_ff.unit_y <= 32'sd1073741824) && (out_ff.unit_y >= -32'sd1073741824) && (out_ff.unit_z <= 32'sd1073741824) && (out_ff.unit_z >= -32'sd1073741824))
   `SGR_ASSERT_NEXT(a_out_kept, clock, reset, out_v_ff && !rsp_tready, out_v_ff)

endmodule

// File: dv/satellite_geometric_range_test.sv
`timescale 1ns / 1ps
module satellite_geometric_range_test;
   import sgr_pkg::*;

   localparam int    LATENCY   = 92;
   localparam int    N_RANDOM  = 660;
   localparam longint MAX_CYCLES = 400000;
   localparam logic [127:0] K_SAG = 128'd1148662658;

   typedef struct packed {
      logic signed [IN_W-1:0] rz, ry, rx, sz, sy, sx;
   } pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   pair_type pending_pairs[$];
   rsp_type expected_fixes[$];
   int     errors = 0;
   int     src_idle_pct = 0;
   int     snk_idle_pct = 0;
   int     hold_rx = 0;     // cycles left of a long receiver hold-off
   bit     drain_pause = 0; // sender offers no new items while set
   bit     req_acc = 0;     // item taken at the last rising edge
   longint cycles = 0;

   satellite_geometric_range u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [127:0] abs128(input logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Rounded integer square root of a non-negative value below 2^100
   function automatic logic [63:0] root_nearest(input logic [127:0] s);
      logic [63:0] r;
      logic [63:0] c;
      logic [127:0] rem;
      r = '0;
      for (int b = 49; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      rem = s - {64'd0, r} * {64'd0, r};
      return rem > r ? r + 1 : r;
   endfunction

   // Q2.30 direction cosine, rounded half away from zero
   function automatic logic [UNIT_W-1:0] cosine_q30(input logic signed [63:0] d,
                                                    input logic [63:0] r);
      logic [127:0] m;
      logic [127:0] q;
      if (r == 0) return '0;
      m = abs128(128'(d));
      q = ((m << 31) + r) / ({64'd0, r} << 1);
      return d < 0 ? UNIT_W'(-q) : UNIT_W'(q);
   endfunction

   function automatic rsp_type range_fix(input pair_type p);
      rsp_type o;
      logic signed [63:0] dx, dy, dz;
      logic [127:0] ssat, s, cm, tm;
      logic signed [127:0] c;
      logic [63:0] r;
      logic signed [127:0] total;
      logic [127:0] re;
      o = '0;
      re = 128'(6378137) << POS_FRAC_BITS;
      ssat = abs128(p.sx) * abs128(p.sx) + abs128(p.sy) * abs128(p.sy)
           + abs128(p.sz) * abs128(p.sz);
      if (ssat < re * re) return o;
      dx = 64'(p.sx) - 64'(p.rx);
      dy = 64'(p.sy) - 64'(p.ry);
      dz = 64'(p.sz) - 64'(p.rz);
      s = abs128(dx) * abs128(dx) + abs128(dy) * abs128(dy) + abs128(dz) * abs128(dz);
      r = root_nearest(s);
      c = 128'(p.sx) * 128'(p.ry) - 128'(p.sy) * 128'(p.rx);
      cm = abs128(c);
      // 96-bit magnitude times 31-bit constant fits in 128 bits
      tm = (cm * K_SAG + (128'd1 << (71 + POS_FRAC_BITS))) >> (72 + POS_FRAC_BITS);
      total = c < 0 ? 128'(r) - 128'(tm) : 128'(r) + 128'(tm);
      if (total < 0) total = 0;
      if (total > 128'h7FFF_FFFF_FFFF) total = 128'h7FFF_FFFF_FFFF;
      o.valid_res = 1'b1;
      o.range = total[RANGE_W-1:0];
      o.unit_x = cosine_q30(dx, r);
      o.unit_y = cosine_q30(dy, r);
      o.unit_z = cosine_q30(dz, r);
      return o;
   endfunction

   function automatic logic signed [IN_W-1:0] rnd48();
      return IN_W'({$urandom(), $urandom()});
   endfunction

   // Orbit-like coordinate: magnitude up to about 2^41 (about 33500 km)
   function automatic logic signed [IN_W-1:0] orbit_coord();
      logic signed [IN_W-1:0] v;
      v = IN_W'({$urandom(), $urandom()} & 64'h1FF_FFFF_FFFF);
      return $urandom_range(1) ? -v : v;
   endfunction

   function automatic logic signed [IN_W-1:0] ground_coord();
      logic signed [IN_W-1:0] v;
      v = IN_W'({$urandom(), $urandom()} & 64'h3F_FFFF_FFFF);
      return $urandom_range(1) ? -v : v;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      case ($urandom_range(9))
         0, 1: begin
            p = {rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48()};
         end
         2: begin
            p.sx = orbit_coord(); p.sy = orbit_coord(); p.sz = orbit_coord();
            p.rx = p.sx; p.ry = p.sy; p.rz = p.sz;
         end
         default: begin
            p.sx = orbit_coord(); p.sy = orbit_coord(); p.sz = orbit_coord();
            p.rx = ground_coord(); p.ry = ground_coord(); p.rz = ground_coord();
         end
      endcase
      return p;
   endfunction

   // Driver: hold data until accepted, change at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_acc) begin
            if (pending_pairs.size() != 0 && !drain_pause
                && $urandom_range(99) >= src_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_pairs.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: long hold-off when asked, else random idling
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_rx > 0) begin
            rsp_tready <= 1'b0;
            hold_rx <= hold_rx - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   // Monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      cycles <= cycles + 1;
      req_acc = !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_fixes.push_back(range_fix(pair_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got.valid_res = rsp_tuser[0];
            got.range  = rsp_tdata[RANGE_W-1:0];
            got.unit_x = rsp_tdata[RANGE_W +: UNIT_W];
            got.unit_y = rsp_tdata[RANGE_W + UNIT_W +: UNIT_W];
            got.unit_z = rsp_tdata[RANGE_W + 2*UNIT_W +: UNIT_W];
            if (expected_fixes.size() == 0) begin
               $error("result with nothing expected");
               errors++;
            end else begin
               want = expected_fixes.pop_front();
               if (got.valid_res !== want.valid_res) begin
                  $error("valid_res exp %0d got %0d", want.valid_res, got.valid_res);
                  errors++;
               end
               if (got.range !== want.range) begin
                  $error("range exp %0d got %0d", want.range, got.range);
                  errors++;
               end
               if (got.unit_x !== want.unit_x) begin
                  $error("unit_x exp %0d got %0d", want.unit_x, got.unit_x);
                  errors++;
               end
               if (got.unit_y !== want.unit_y) begin
                  $error("unit_y exp %0d got %0d", want.unit_y, got.unit_y);
                  errors++;
               end
               if (got.unit_z !== want.unit_z) begin
                  $error("unit_z exp %0d got %0d", want.unit_z, got.unit_z);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles > MAX_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || req_tvalid || expected_fixes.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      pair_type p;
      logic signed [IN_W-1:0] re_fix;
      logic signed [IN_W-1:0] mx, mn;
      re_fix = IN_W'(6378137) << POS_FRAC_BITS;
      mx = {1'b0, {(IN_W-1){1'b1}}};
      mn = {1'b1, {(IN_W-1){1'b0}}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, inside earth, exact radius, coincident points
      pending_pairs.push_back('{rz: 0, ry: 0, rx: 0, sz: 0, sy: 0, sx: 0});
      pending_pairs.push_back('{rz: 0, ry: 0, rx: 0, sz: 0, sy: 0, sx: re_fix - 1});
      pending_pairs.push_back('{rz: 0, ry: 0, rx: 0, sz: 0, sy: 0, sx: re_fix});
      pending_pairs.push_back('{rz: 0, ry: 0, rx: 0, sz: -re_fix, sy: 0, sx: 0});
      pending_pairs.push_back('{rz: 0, ry: 0, rx: re_fix, sz: 0, sy: 0, sx: re_fix});
      pending_pairs.push_back('{rz: mn, ry: mn, rx: mn, sz: mx, sy: mx, sx: mx});
      pending_pairs.push_back('{rz: mx, ry: mx, rx: mx, sz: mn, sy: mn, sx: mn});
      pending_pairs.push_back('{rz: mx, ry: mn, rx: mx, sz: mn, sy: mx, sx: mn});
      pending_pairs.push_back('{rz: 0, ry: mx, rx: mn, sz: 0, sy: mn, sx: mx});
      pending_pairs.push_back('{rz: 0, ry: mn, rx: mn, sz: 0, sy: mx, sx: mx});
      pending_pairs.push_back('{rz: -1, ry: -1, rx: -1, sz: mx, sy: mx, sx: mx});
      pending_pairs.push_back('{rz: 0, ry: 0, rx: 0, sz: mn, sy: mn, sx: mn});
      pending_pairs.push_back('{rz: mx, ry: mx, rx: mx, sz: mx, sy: mx, sx: mx});
      for (int i = 0; i < 8; i++) begin
         p.sx = orbit_coord(); p.sy = orbit_coord(); p.sz = orbit_coord();
         p.rx = ground_coord(); p.ry = ground_coord(); p.rz = ground_coord();
         pending_pairs.push_back(p);
      end
      wait_drained();

      // Long receiver hold-off while the sender keeps offering items
      hold_rx = 400;
      for (int i = 0; i < 200; i++) pending_pairs.push_back(random_pair());
      // Wait until everything is back, then pause the sender
      wait_drained();
      drain_pause = 1;
      repeat (20) @(posedge clock);
      drain_pause = 0;

      for (int ph = 0; ph < 3; ph++) begin
         src_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 83 : 0;
         snk_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 17 : 0;
         for (int i = 0; i < N_RANDOM / 3; i++) pending_pairs.push_back(random_pair());
         wait_drained();
      end
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0 && expected_fixes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/sgr_pkg.sv
hdl/satellite_geometric_range.sv
dv/satellite_geometric_range_test.sv
